FILE: hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg - shared types and constants for the text console char engine
// Geometry, field widths, control codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

  // screen geometry
  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = ROWS * COLUMNS;

  // widths
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int LIN_W_MIN = $clog2(CELLS + 1);
  localparam int IDX_W     = 11;
  localparam int POS_W     = 11;
  localparam int BYTE_W    = 8;
  localparam int LIN_W     = (LIN_W_MIN > IDX_W) ? LIN_W_MIN : IDX_W;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int COL_W     = $clog2(COLUMNS);

  localparam int TAB_STEP  = 8;

  // character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [BYTE_W-1:0] CH_TAB       = 8'd9;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [BYTE_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [BYTE_W-1:0] FILL_RESET   = 8'hF0;

  // request opcode
  localparam logic OP_READ = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic take;          // latch the accepted request
    logic calc;          // form the logical cell address
    logic access;        // memory access and cursor update
    logic clr_row_load;  // arm the clear walker on the exposed row
    logic clr_step;      // write one blank cell
    logic load;          // load the output register
  } tcce_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scroll;        // current put needs a scroll
    logic clr_last;      // clear walker on its final cell
    logic out_free;      // output register can take a result
  } tcce_sts_t;

endpackage

`default_nettype wire

FILE: hdl/tcce_in_if.sv
// ----------------------------------------------------------------------------
// tcce_in_if - request channel of the text console char engine
// valid/ready handshake carrying op, char_code and read_index.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcce_in_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [BYTE_W-1:0] char_code;
  logic [IDX_W-1:0]  read_index;

  modport source (output valid, op, char_code, read_index, input ready);
  modport sink   (input valid, op, char_code, read_index, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcce_out_if.sv
// ----------------------------------------------------------------------------
// tcce_out_if - result channel of the text console char engine
// valid/ready handshake carrying cursor_pos, cell_char and cell_attr.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcce_out_if;
  import tcce_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_pos;
  logic [BYTE_W-1:0] cell_char;
  logic [BYTE_W-1:0] cell_attr;

  modport source (output valid, cursor_pos, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_pos, cell_char, cell_attr, output ready);
endinterface

`default_nettype wire

FILE: hdl/tcce_ctrl.sv
// ----------------------------------------------------------------------------
// tcce_ctrl - sequencer for the text console char engine
// Runs the power-on clear, then one request at a time: address, access,
// optional scroll clear, result load.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tcce_pkg::tcce_sts_t   sts,
  output tcce_pkg::tcce_cmd_t   cmd
);
  import tcce_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_ACCESS,
    ST_SCROLL,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_ACCESS;
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
        if (sts.scroll) begin
          cmd.clr_row_load = 1'b1;
          state_nxt        = ST_SCROLL;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_SCROLL: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/tcce_datapath.sv
// ----------------------------------------------------------------------------
// tcce_datapath - cell store, cursor and result register
// The store is a circular buffer; base_r is the physical start of row 0, so a
// scroll is a base step plus a clear of one row.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcce_pkg::tcce_cmd_t           cmd,
  output tcce_pkg::tcce_sts_t           sts,
  input  logic                          in_op,
  input  logic [tcce_pkg::BYTE_W-1:0]   in_char_code,
  input  logic [tcce_pkg::IDX_W-1:0]    in_read_index,
  input  logic                          cfg_we,
  input  logic [tcce_pkg::BYTE_W-1:0]   cfg_wdata,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [tcce_pkg::POS_W-1:0]    out_cursor_pos,
  output logic [tcce_pkg::BYTE_W-1:0]   out_cell_char,
  output logic [tcce_pkg::BYTE_W-1:0]   out_cell_attr
);
  import tcce_pkg::*;

  // cell store, split by byte so a put needs no read-modify-write
  logic [BYTE_W-1:0] char_mem [CELLS];
  logic [BYTE_W-1:0] attr_mem [CELLS];

  // latched request
  logic              op_r;
  logic [BYTE_W-1:0] char_r;
  logic [IDX_W-1:0]  ridx_r;

  // cursor and buffer origin
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;

  logic [LIN_W-1:0]  lin_r;
  logic              rd_ok_r;
  logic [BYTE_W-1:0] rchar_r, rattr_r;
  logic [BYTE_W-1:0] fill_r;

  // clear walker
  logic [ADDR_W-1:0] clr_addr_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              clr_boot_r;

  logic              out_valid_r;
  logic [POS_W-1:0]  out_pos_r;
  logic [BYTE_W-1:0] out_char_r, out_attr_r;

  logic              is_read, is_nl, is_tab, is_bs, is_plain;
  logic [COL_W-1:0]  col_eff;
  logic [COL_W:0]    col_ext, tab_col, inc_col;
  logic              lf, last_row;
  logic [LIN_W-1:0]  row_lin;
  logic [ADDR_W:0]   phys_sum, base_sum;
  logic [ADDR_W-1:0] phys, base_wrap;
  logic              char_we, attr_we, mem_rd;
  logic [ADDR_W-1:0] waddr;
  logic [BYTE_W-1:0] wchar, wattr;

  // ---- decode ----
  assign is_read  = (op_r == OP_READ);
  assign is_nl    = (char_r == CH_NEWLINE);
  assign is_tab   = (char_r == CH_TAB);
  assign is_bs    = (char_r == CH_BACKSPACE);
  assign is_plain = !is_nl && !is_tab && !is_bs;

  assign col_eff  = (is_bs && col_r != '0) ? col_r - COL_W'(1) : col_r;
  assign col_ext  = {1'b0, col_r};
  assign tab_col  = (col_ext + (COL_W+1)'(TAB_STEP)) & ~((COL_W+1)'(TAB_STEP - 1));
  assign inc_col  = col_ext + (COL_W+1)'(1);
  assign last_row = (row_r == ROW_W'(ROWS - 1));

  assign lf = !is_read &&
              (is_nl ||
               (is_tab   && tab_col >= (COL_W+1)'(COLUMNS)) ||
               (is_plain && inc_col >= (COL_W+1)'(COLUMNS)));

  assign row_lin = LIN_W'(row_r) * LIN_W'(COLUMNS);

  // logical -> physical; both operands below CELLS whenever the address is used
  assign phys_sum = {1'b0, lin_r[ADDR_W-1:0]} + {1'b0, base_r};
  assign phys     = (phys_sum >= (ADDR_W+1)'(CELLS)) ?
                    ADDR_W'(phys_sum - (ADDR_W+1)'(CELLS)) : phys_sum[ADDR_W-1:0];

  assign base_sum  = {1'b0, base_r} + (ADDR_W+1)'(COLUMNS);
  assign base_wrap = (base_sum >= (ADDR_W+1)'(CELLS)) ?
                     ADDR_W'(base_sum - (ADDR_W+1)'(CELLS)) : base_sum[ADDR_W-1:0];

  assign sts.scroll   = lf && last_row;
  assign sts.clr_last = (clr_cnt_r == '0);
  assign sts.out_free = !out_valid_r || out_ready;

  // ---- cursor update ----
  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    base_nxt = base_r;
    if (cmd.access && !is_read) begin
      if (lf) begin
        col_nxt = '0;
        if (last_row) base_nxt = base_wrap;
        else          row_nxt  = row_r + ROW_W'(1);
      end else if (is_tab) begin
        col_nxt = tab_col[COL_W-1:0];
      end else if (is_bs) begin
        col_nxt = col_eff;
      end else begin
        col_nxt = inc_col[COL_W-1:0];
      end
    end
  end

  // ---- memory port selection ----
  assign char_we = cmd.clr_step || (cmd.access && !is_read && (is_bs || is_plain));
  assign attr_we = cmd.clr_step;
  assign mem_rd  = cmd.access && is_read && rd_ok_r;
  assign waddr   = cmd.clr_step ? clr_addr_r : phys;
  assign wchar   = (cmd.clr_step || is_bs) ? CH_SPACE : char_r;
  assign wattr   = clr_boot_r ? FILL_RESET : fill_r;

  always_ff @(posedge clk) begin
    if (char_we) char_mem[waddr] <= wchar;
    if (mem_rd)  rchar_r <= char_mem[phys];
  end

  always_ff @(posedge clk) begin
    if (attr_we) attr_mem[waddr] <= wattr;
    if (mem_rd)  rattr_r <= attr_mem[phys];
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      op_r   <= in_op;
      char_r <= in_char_code;
      ridx_r <= in_read_index;
    end
    if (cmd.calc) begin
      lin_r   <= is_read ? LIN_W'(ridx_r) : row_lin + LIN_W'(col_eff);
      rd_ok_r <= LIN_W'(ridx_r) < LIN_W'(CELLS);
    end
    if (cmd.load) begin
      out_pos_r  <= POS_W'(row_lin + LIN_W'(col_r));
      out_char_r <= (is_read && rd_ok_r) ? rchar_r : '0;
      out_attr_r <= (is_read && rd_ok_r) ? rattr_r : '0;
    end
  end

  // ---- control state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      base_r      <= '0;
      fill_r      <= FILL_RESET;
      clr_addr_r  <= '0;
      clr_cnt_r   <= ADDR_W'(CELLS - 1);
      clr_boot_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      base_r <= base_nxt;
      if (cfg_we) fill_r <= cfg_wdata;
      if (cmd.clr_row_load) begin
        clr_addr_r <= base_r;          // old top row becomes the new bottom row
        clr_cnt_r  <= ADDR_W'(COLUMNS - 1);
        clr_boot_r <= 1'b0;
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
        clr_cnt_r  <= clr_cnt_r - ADDR_W'(1);
      end
      if (cmd.load)     out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_char  = out_char_r;
  assign out_cell_attr  = out_attr_r;

endmodule

`default_nettype wire

FILE: hdl/text_console_char_engine.sv
// ----------------------------------------------------------------------------
// text_console_char_engine - 80x25 text console with cursor and scrolling
// Request channel in_ch (op, char_code, read_index), result channel out_ch
// (cursor_pos, cell_char, cell_attr), write-only register cfg_* holding the
// fill attribute used for rows exposed by a scroll.
//
// Usage notes:
//  - One result per request. A put handles newline, tab, backspace or an
//    ordinary byte at the cursor; a read returns one cell. Every result
//    carries the cursor position after the request.
//  - Requests are handled one at a time: accept, address, store access,
//    result load.
//  - A put that scrolls adds a blank-row walk of COLUMNS cells (80)
//    through the cell store's single write port.
//  - After reset the store is swept once, one cell per cycle, over all CELLS
//    cells (2000); in_ch.ready stays low meanwhile. cfg writes are taken any time.
//  - The result sits in an output register. A new request is accepted while
//    it waits; if out_ch is stalled, that next request holds in its last
//    step until the register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_char_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  tcce_in_if.sink                      in_ch,
  tcce_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic [tcce_pkg::BYTE_W-1:0]  cfg_wdata
);
  import tcce_pkg::*;

  tcce_cmd_t cmd;
  tcce_sts_t sts;

  // sequencer
  tcce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, cursor, result register
  tcce_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_op          (in_ch.op),
    .in_char_code   (in_ch.char_code),
    .in_read_index  (in_ch.read_index),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_cursor_pos (out_ch.cursor_pos),
    .out_cell_char  (out_ch.cell_char),
    .out_cell_attr  (out_ch.cell_attr)
  );

  // ---- assertions ----

  // single request in flight
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // no request taken while the clear walker owns the store
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !in_ch.ready)
    else $error("request port open during clear walk");

  // reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> LIN_W'(out_ch.cursor_pos) < LIN_W'(CELLS))
    else $error("cursor position beyond screen");

  // a result is only loaded into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote a pending result");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for text_console_char_engine
// Streams put and read requests through the engine with random gaps on the
// request side and random stalls on the result side. A local screen, cursor
// and fill attribute track what the engine must hold, and every result is
// checked field by field. The fill attribute is rewritten between traffic
// phases while the engine is quiet.
// ----------------------------------------------------------------------------
module tb_top;
  import tcce_pkg::*;

  // put is the other request code
  localparam logic OP_PUT = ~OP_READ;

  localparam int CLK_HALF = 10;
  // extra quiet time before a register write; a blank-row walk ends before
  // its result, so this is margin only
  localparam int SETTLE_CYCLES = COLUMNS + 20;

  typedef struct packed {
    logic              op;
    logic [BYTE_W-1:0] char_code;
    logic [IDX_W-1:0]  read_index;
  } console_req_t;

  typedef struct packed {
    logic [POS_W-1:0]  cursor_pos;
    logic [BYTE_W-1:0] cell_char;
    logic [BYTE_W-1:0] cell_attr;
  } console_report_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  tcce_in_if  in_ch ();
  tcce_out_if out_ch ();

  text_console_char_engine u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Screen tracking: cell = {attribute, character}
  // --------------------------------------------------------------------------
  logic [2*BYTE_W-1:0] screen_cells [CELLS];
  logic [ROW_W-1:0]    cur_row;
  logic [COL_W:0]      cur_col;     // one spare bit above COL_W, matching the engine's column sums
  logic [BYTE_W-1:0]   fill_attr;

  console_req_t    typed_reqs[$];       // requests not yet presented
  console_report_t pending_reports[$];  // results owed by the engine

  int  reqs_queued;
  int  results_seen;
  int  errors;
  bit  req_fire;     // request taken at the last rising edge
  bit  idle_on;      // random gaps and stalls enabled
  int  src_gap;
  int  sink_hold;

  // Next row, or scroll the whole screen up by one row on the bottom row.
  function automatic void scroll_or_next_row();
    int i;
    if (cur_row >= ROWS - 1) begin
      cur_row = ROW_W'(ROWS - 1);
      for (i = 0; i < CELLS - COLUMNS; i++) screen_cells[i] = screen_cells[i + COLUMNS];
      for (i = CELLS - COLUMNS; i < CELLS; i++) screen_cells[i] = {fill_attr, CH_SPACE};
    end else begin
      cur_row = cur_row + 1'b1;
    end
    cur_col = '0;
  endfunction

  // Apply one request to the tracked screen and return the result it owes.
  function automatic console_report_t next_console_report(console_req_t req);
    console_report_t rep;
    int              cell_idx;
    rep      = '0;
    cell_idx = int'(cur_row) * COLUMNS + int'(cur_col);
    if (req.op == OP_READ) begin
      // reads past the end of the store return zeros
      if (req.read_index < CELLS) begin
        rep.cell_char = screen_cells[req.read_index][BYTE_W-1:0];
        rep.cell_attr = screen_cells[req.read_index][2*BYTE_W-1:BYTE_W];
      end
    end else begin
      case (req.char_code)
        CH_NEWLINE: begin
          scroll_or_next_row();
        end
        CH_TAB: begin
          cur_col = (COL_W+1)'(((int'(cur_col) + TAB_STEP) / TAB_STEP) * TAB_STEP);
          if (cur_col >= COLUMNS) scroll_or_next_row();
        end
        CH_BACKSPACE: begin
          // stops at column 0, still blanks the character there
          if (cur_col != 0) cur_col = cur_col - 1'b1;
          cell_idx = int'(cur_row) * COLUMNS + int'(cur_col);
          screen_cells[cell_idx][BYTE_W-1:0] = CH_SPACE;
        end
        default: begin
          // attribute of the cell is kept
          screen_cells[cell_idx][BYTE_W-1:0] = req.char_code;
          cur_col = cur_col + 1'b1;
          if (cur_col >= COLUMNS) scroll_or_next_row();
        end
      endcase
    end
    rep.cursor_pos = POS_W'(int'(cur_row) * COLUMNS + int'(cur_col));
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_req(logic op, logic [BYTE_W-1:0] ch, logic [IDX_W-1:0] idx);
    console_req_t req;
    req.op         = op;
    req.char_code  = ch;
    req.read_index = idx;
    typed_reqs.push_back(req);
    reqs_queued++;
  endtask

  // Mostly text with frequent control bytes so rows wrap and the screen
  // scrolls often; a quarter are reads, half of those aimed at the bottom
  // rows where fresh text sits once scrolling has started.
  task automatic queue_random(int count);
    int                n;
    int                roll;
    logic [BYTE_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      ch   = BYTE_W'($urandom);
      idx  = IDX_W'($urandom);
      if (roll < 25) begin
        if (roll < 12) idx = IDX_W'($urandom_range(CELLS - 6 * COLUMNS, CELLS - 1));
        queue_req(OP_READ, ch, idx);
      end else begin
        if (roll < 36)      ch = CH_NEWLINE;
        else if (roll < 44) ch = CH_TAB;
        else if (roll < 52) ch = CH_BACKSPACE;
        queue_req(OP_PUT, ch, idx);
      end
    end
  endtask

  // Wait until every queued request has produced its result, then idle a
  // while longer. Called and returns at a falling edge.
  task automatic wait_quiet();
    while (results_seen < reqs_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // One-cycle register write; engine is idle, so the tracked copy follows.
  task automatic write_fill_attr(logic [BYTE_W-1:0] val);
    cfg_wdata <= val;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fill_attr  = val;
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  always #(CLK_HALF) clk = ~clk;

  // --------------------------------------------------------------------------
  // Request driver: holds a request until taken, inserts random idle bursts
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    console_req_t nxt;
    if (rst_n && !(in_ch.valid && !req_fire)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        // start a random idle burst
        src_gap = $urandom_range(0, 3);
        in_ch.valid <= 1'b0;
      end else if (typed_reqs.size() != 0) begin
        nxt = typed_reqs.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.op         <= nxt.op;
        in_ch.char_code  <= nxt.char_code;
        in_ch.read_index <= nxt.read_index;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result sink: random stall bursts
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (sink_hold > 0) begin
        sink_hold--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        sink_hold = $urandom_range(0, 3);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check results first, then predict for a request taken this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    console_report_t want;
    console_report_t got;
    console_req_t    taken;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cursor_pos = out_ch.cursor_pos;
      got.cell_char  = out_ch.cell_char;
      got.cell_attr  = out_ch.cell_attr;
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: result with no request pending: pos=%0d char=%02h attr=%02h",
                 $time, got.cursor_pos, got.cell_char, got.cell_attr);
      end else begin
        want = pending_reports.pop_front();
        results_seen++;
        if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
            got.cell_attr !== want.cell_attr) begin
          errors++;
          $display("%0t: mismatch expected pos=%0d char=%02h attr=%02h, actual pos=%0d char=%02h attr=%02h",
                   $time, want.cursor_pos, want.cell_char, want.cell_attr,
                   got.cursor_pos, got.cell_char, got.cell_attr);
        end
      end
    end
    req_fire = rst_n && in_ch.valid && in_ch.ready;
    if (req_fire) begin
      taken.op         = in_ch.op;
      taken.char_code  = in_ch.char_code;
      taken.read_index = in_ch.read_index;
      pending_reports.push_back(next_console_report(taken));
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, directed requests, then random phases per fill attribute
  // --------------------------------------------------------------------------
  initial begin
    int i;
    clk              = 1'b0;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_PUT;
    in_ch.char_code  = '0;
    in_ch.read_index = '0;
    out_ch.ready     = 1'b0;
    idle_on          = 1'b1;
    reqs_queued      = 0;
    results_seen     = 0;
    errors           = 0;
    src_gap          = 0;
    sink_hold        = 0;
    fill_attr        = FILL_RESET;
    cur_row          = '0;
    cur_col          = '0;
    for (i = 0; i < CELLS; i++) screen_cells[i] = {FILL_RESET, CH_SPACE};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset contents at both ends, out-of-range reads, backspace
    // at column 0, byte extremes, backspace blanking, tab walk to the row
    // end with wrap, newline. The engine's post-reset sweep holds these off.
    queue_req(OP_READ, '0, '0);
    queue_req(OP_READ, '0, IDX_W'(CELLS - 1));
    queue_req(OP_READ, '0, IDX_W'(CELLS));
    queue_req(OP_READ, '0, '1);
    queue_req(OP_PUT, CH_BACKSPACE, '0);
    queue_req(OP_PUT, 8'hFF, '0);
    queue_req(OP_PUT, 8'h00, '0);
    queue_req(OP_PUT, 8'h41, '0);
    queue_req(OP_PUT, CH_BACKSPACE, '0);
    queue_req(OP_READ, '0, IDX_W'(0));
    queue_req(OP_READ, '0, IDX_W'(1));
    queue_req(OP_READ, '0, IDX_W'(2));
    repeat (COLUMNS / TAB_STEP) queue_req(OP_PUT, CH_TAB, '0);
    queue_req(OP_PUT, CH_NEWLINE, '0);
    queue_req(OP_READ, '0, IDX_W'(COLUMNS));
    queue_random(230);
    wait_quiet();

    // low extreme of the fill attribute
    write_fill_attr(8'h00);
    queue_random(260);
    wait_quiet();

    // high extreme
    write_fill_attr(8'hFF);
    queue_random(260);
    wait_quiet();

    // a middle value, then a stretch at full rate with no gaps or stalls
    write_fill_attr(BYTE_W'($urandom_range(1, 254)));
    queue_random(120);
    wait_quiet();
    idle_on = 1'b0;
    queue_random(160);
    wait_quiet();

    if (errors == 0 && pending_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
